[src/mavt_pkg.sv]
// Shared widths, codes and types of the moving average and variance tracker.
`timescale 1ns / 1ps
`default_nettype none
package mavt_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 17;
  localparam int MEAN_W   = 16;
  localparam int VAR_W    = 31;
  localparam int LEN_W    = 7;
  localparam int ACC_W    = 32;
  localparam int CNT_W    = 32;
  localparam int VSUM_W   = 64;
  localparam int FRAC     = 16;
  localparam int ONE_Q16  = 65536;
  localparam int VAR_MAX  = 1073741824;

  localparam int NUM_W = 64;
  localparam int DEN_W = 32;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_LEN  = 1'b1;

  typedef enum logic [1:0] {
    MODE_CUM   = 2'd0,
    MODE_WIN   = 2'd1,
    MODE_DECAY = 2'd2,
    MODE_HOLD  = 2'd3
  } mode_e;

endpackage
`default_nettype wire

[src/mavt_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module mavt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

[src/mavt_div.sv]
// Iterative restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mavt_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [mavt_pkg::NUM_W-1:0] num_i,
  input  wire logic [mavt_pkg::DEN_W-1:0] den_i,
  output logic                         done_o,
  output logic      [mavt_pkg::NUM_W-1:0] quo_o
);
  import mavt_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

[src/moving_average_variance_tracker_unit.sv]
// Top level of the moving average and variance tracker.
// Usage:
//   Input channel: sample_i (signed Q1.15) and weight_i (Q1.16) with in_valid_i; a request
//   is taken at a clock edge with in_valid_i high and in_stall_o low.
//   Output channel: mean_o and variance_o with out_valid_o; taken when out_stall_i is low.
//   APB port: register 0 at address 0 selects the mode, register 1 at address 4 the window
//   length. Write only while no request is in flight.
//   Each request gives one result. One request is worked at a time; the shared divider
//   serves the mean and variance steps of a request in turn. A request is accepted while
//   the previous result still waits in the output register.
//   The window samples live in a RAM of MAX_WINDOW entries, read in the ST_RD state ahead
//   of the update and written back at its end; no clearing pass is needed after reset.
//   Reset clears the mean, count, variance sum and window state, and sets mode 0, length 1.
//   When the receiver stalls, the finished result holds in the output register and the
//   next result waits in its last step until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module moving_average_variance_tracker_unit #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic signed [mavt_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic [mavt_pkg::WEIGHT_W-1:0]   weight_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [mavt_pkg::MEAN_W-1:0]   mean_o,
  output logic [mavt_pkg::VAR_W-1:0]           variance_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mavt_pkg::APB_AW-1:0]     paddr,
  input  wire logic [mavt_pkg::APB_DW-1:0]     pwdata,
  output logic [mavt_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);
  import mavt_pkg::*;

  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW = $clog2(MAX_WINDOW + 1);
  localparam int TW = PW + 17;
  localparam logic signed [TW:0] TOT_LIM = (TW + 1)'(MAX_WINDOW * 32768);
  localparam logic signed [65:0] MEAN_HI = 66'sd2147418112;
  localparam logic signed [65:0] MEAN_LO = -66'sd2147483648;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CNT   = 5'd1;
  localparam logic [4:0] ST_RD    = 5'd2;
  localparam logic [4:0] ST_TOT   = 5'd3;
  localparam logic [4:0] ST_WDIV  = 5'd4;
  localparam logic [4:0] ST_MDIV  = 5'd5;
  localparam logic [4:0] ST_MEAN  = 5'd6;
  localparam logic [4:0] ST_OPS   = 5'd7;
  localparam logic [4:0] ST_MUL   = 5'd8;
  localparam logic [4:0] ST_ACC   = 5'd9;
  localparam logic [4:0] ST_PRIME = 5'd10;
  localparam logic [4:0] ST_E1    = 5'd11;
  localparam logic [4:0] ST_E2    = 5'd12;
  localparam logic [4:0] ST_E3    = 5'd13;
  localparam logic [4:0] ST_E4    = 5'd14;
  localparam logic [4:0] ST_E5    = 5'd15;
  localparam logic [4:0] ST_VAR   = 5'd16;
  localparam logic [4:0] ST_VDIV  = 5'd17;
  localparam logic [4:0] ST_OUT   = 5'd18;

  function automatic logic signed [ACC_W-1:0] clamp_mean(input logic signed [65:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > MEAN_HI) begin
      r = 32'sh7FFF0000;
    end else if (v < MEAN_LO) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(v[ACC_W-1:0]);
    end
    return r;
  endfunction

  // configuration
  mode_e             mode_q;
  logic [LEN_W-1:0]  wlen_q;
  logic [LEN_W-1:0]  len_eff;
  logic              cfg_wr;

  // control
  logic [4:0]        state_q, state_d;
  logic              pass_q, pass_d;
  logic              qneg_q, qneg_d;
  logic              out_valid_q;
  logic              out_load;

  // block state
  logic signed [ACC_W-1:0]    mean_acc_q, mean_acc_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic signed [VSUM_W-1:0]   vsum_q, vsum_d;
  logic [PW-1:0]              wptr_q, wptr_d;
  logic signed [TW-1:0]       wtotal_q, wtotal_d;
  logic                       primed_q, primed_d;
  logic signed [SAMPLE_W-1:0] prime_q, prime_d;
  logic [SW-1:0]              wslots_q, wslots_d;

  // working registers
  logic signed [SAMPLE_W-1:0] x_q, x_d;
  logic [WEIGHT_W-1:0]        w_q, w_d;
  logic signed [ACC_W-1:0]    prev_q, prev_d;
  logic signed [SAMPLE_W-1:0] oldest_q, oldest_d;
  logic [31:0]                op_a_q, op_a_d;
  logic [31:0]                op_b_q, op_b_d;
  logic                       op_neg_q, op_neg_d;
  logic [63:0]                prod_q;
  logic signed [49:0]         t1_q, t1_d;
  logic [VAR_W-1:0]           var_q, var_d;
  logic signed [MEAN_W-1:0]   mean_out_q;
  logic [VAR_W-1:0]           var_out_q;

  // datapath intermediates
  logic signed [32:0]         xq;
  logic signed [32:0]         oq;
  logic signed [32:0]         base;
  logic signed [32:0]         diff;
  logic [32:0]                dmag;
  logic [CNT_W-1:0]           cnt_inc;
  logic signed [SAMPLE_W-1:0] oldest;
  logic signed [TW:0]         tsum;
  logic [TW-1:0]              tmag;
  logic signed [65:0]         q66;
  logic signed [65:0]         mc;
  logic signed [33:0]         da;
  logic signed [33:0]         db;
  logic [33:0]                ma;
  logic [33:0]                mb;
  logic signed [64:0]         term;
  logic signed [64:0]         vs;
  logic [31:0]                wptr_nxt;
  logic [SAMPLE_W-1:0]        xa;
  logic [ACC_W-1:0]           mabs;
  logic signed [49:0]         p1;
  logic signed [49:0]         v2;
  logic signed [49:0]         s50;
  logic [49:0]                smag;
  logic signed [TW-1:0]       xt;
  logic signed [TW-1:0]       lt;
  logic [47:0]                vq;
  logic [32:0]                mmag;
  logic [16:0]                mq;

  // divider and RAM hookup
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic              ram_we;
  logic [SAMPLE_W-1:0] ram_rdata;

  mavt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  mavt_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i (x_q),
    .raddr_i (wptr_q),
    .rdata_o (ram_rdata)
  );

  // configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_MODE: prdata = {{(APB_DW - 2){1'b0}}, mode_q};
      REG_LEN:  prdata = {{(APB_DW - LEN_W){1'b0}}, wlen_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CUM;
      wlen_q <= LEN_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MODE: mode_q <= mode_e'(pwdata[1:0]);
        REG_LEN:  wlen_q <= pwdata[LEN_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (wlen_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(wlen_q) > MAX_WINDOW) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = wlen_q;
    end
  end

  // fixed intermediates
  assign xq       = $signed({x_q[SAMPLE_W-1], x_q, 16'b0});
  assign oq       = $signed({oldest_q[SAMPLE_W-1], oldest_q, 16'b0});
  assign base     = pass_q ? oq : xq;
  assign diff     = xq - 33'(prev_q);
  assign dmag     = diff[32] ? 33'(-diff) : 33'(diff);
  assign cnt_inc  = (count_q == '1) ? count_q : count_q + 1'b1;
  assign oldest   = (32'(wptr_q) < 32'(wslots_q)) ? $signed(ram_rdata) : prime_q;
  assign tsum     = (TW + 1)'(wtotal_q) - (TW + 1)'(oldest) + (TW + 1)'(x_q);
  assign tmag     = wtotal_q[TW-1] ? TW'(-wtotal_q) : TW'(wtotal_q);
  assign q66      = $signed({2'b0, div_quo});
  assign da       = 34'(base) - 34'(mean_acc_q);
  assign db       = 34'(base) - 34'(prev_q);
  assign ma       = da[33] ? 34'(-da) : 34'(da);
  assign mb       = db[33] ? 34'(-db) : 34'(db);
  assign term     = (op_neg_q ^ pass_q) ? -$signed({17'b0, prod_q[63:16]})
                                        : $signed({17'b0, prod_q[63:16]});
  assign vs       = 65'(vsum_q) + term;
  assign wptr_nxt = 32'(wptr_q) + 32'd1;
  assign xa       = x_q[SAMPLE_W-1] ? SAMPLE_W'(-x_q) : SAMPLE_W'(x_q);
  assign mabs     = mean_acc_q[ACC_W-1] ? ACC_W'(-mean_acc_q) : ACC_W'(mean_acc_q);
  assign p1       = $signed({18'b0, prod_q[31:0]}) <<< 16;
  assign v2       = op_neg_q ? -$signed({2'b0, prod_q[47:0]}) : $signed({2'b0, prod_q[47:0]});
  assign s50      = t1_q + v2;
  assign smag     = s50[49] ? 50'(-s50) : 50'(s50);
  assign xt       = TW'(x_q);
  assign lt       = $signed(TW'(len_eff));
  assign vq       = div_quo[63:16];
  assign mmag     = mean_acc_q[ACC_W-1] ? 33'(-(33'(mean_acc_q))) : 33'(mean_acc_q);
  assign mq       = mmag[32:16];

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    qneg_d     = qneg_q;
    mean_acc_d = mean_acc_q;
    count_d    = count_q;
    vsum_d     = vsum_q;
    wptr_d     = wptr_q;
    wtotal_d   = wtotal_q;
    primed_d   = primed_q;
    prime_d    = prime_q;
    wslots_d   = wslots_q;
    x_d        = x_q;
    w_d        = w_q;
    prev_d     = prev_q;
    oldest_d   = oldest_q;
    op_a_d     = op_a_q;
    op_b_d     = op_b_q;
    op_neg_d   = op_neg_q;
    t1_d       = t1_q;
    var_d      = var_q;
    mc         = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d    = sample_i;
          w_d    = (weight_i > WEIGHT_W'(ONE_Q16)) ? WEIGHT_W'(ONE_Q16) : weight_i;
          prev_d = mean_acc_q;
          pass_d = 1'b0;
          case (mode_q)
            MODE_CUM:   state_d = ST_CNT;
            MODE_WIN:   state_d = primed_q ? ST_RD : ST_PRIME;
            MODE_DECAY: state_d = ST_E1;
            default:    state_d = ST_VAR;
          endcase
        end
      end
      ST_CNT: begin
        count_d   = cnt_inc;
        qneg_d    = diff[32];
        div_start = 1'b1;
        div_num   = NUM_W'(dmag);
        div_den   = cnt_inc;
        state_d   = ST_MDIV;
      end
      ST_RD: begin
        state_d = ST_TOT;
      end
      ST_TOT: begin
        oldest_d = oldest;
        if (tsum > TOT_LIM) begin
          wtotal_d = TW'(TOT_LIM);
        end else if (tsum < -TOT_LIM) begin
          wtotal_d = TW'(-TOT_LIM);
        end else begin
          wtotal_d = TW'(tsum);
        end
        state_d = ST_WDIV;
      end
      ST_WDIV: begin
        qneg_d    = wtotal_q[TW-1];
        div_start = 1'b1;
        div_num   = NUM_W'(tmag) << FRAC;
        div_den   = DEN_W'(len_eff);
        state_d   = ST_MDIV;
      end
      ST_MDIV: begin
        if (div_done) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN: begin
        mc = qneg_q ? -q66 : q66;
        if (mode_q == MODE_CUM) begin
          mc = mc + 66'(prev_q);
        end
        mean_acc_d = clamp_mean(mc);
        state_d    = ST_OPS;
      end
      ST_OPS: begin
        op_a_d   = (ma[33:32] != 2'b00) ? 32'hFFFF_FFFF : ma[31:0];
        op_b_d   = (mb[33:32] != 2'b00) ? 32'hFFFF_FFFF : mb[31:0];
        op_neg_d = da[33] != db[33];
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (vs[64] != vs[63]) begin
          vsum_d = vs[64] ? {1'b1, {(VSUM_W - 1){1'b0}}} : {1'b0, {(VSUM_W - 1){1'b1}}};
        end else begin
          vsum_d = VSUM_W'(vs);
        end
        if (mode_q == MODE_WIN && !pass_q) begin
          pass_d  = 1'b1;
          state_d = ST_OPS;
        end else begin
          if (mode_q == MODE_WIN) begin
            ram_we = 1'b1;
            if (32'(wslots_q) < wptr_nxt) begin
              wslots_d = SW'(wptr_nxt);
            end
            wptr_d = (wptr_nxt >= 32'(len_eff)) ? '0 : PW'(wptr_nxt);
          end
          state_d = ST_VAR;
        end
      end
      ST_PRIME: begin
        primed_d   = 1'b1;
        prime_d    = x_q;
        wslots_d   = '0;
        wptr_d     = '0;
        wtotal_d   = TW'(xt * lt);
        mean_acc_d = ACC_W'(xq);
        vsum_d     = '0;
        state_d    = ST_VAR;
      end
      ST_E1: begin
        op_a_d   = 32'(xa);
        op_b_d   = 32'(w_q);
        op_neg_d = x_q[SAMPLE_W-1];
        state_d  = ST_E2;
      end
      ST_E2: begin
        state_d = ST_E3;
      end
      ST_E3: begin
        t1_d     = op_neg_q ? -p1 : p1;
        op_a_d   = mabs;
        op_b_d   = 32'(WEIGHT_W'(ONE_Q16) - w_q);
        op_neg_d = mean_acc_q[ACC_W-1];
        state_d  = ST_E4;
      end
      ST_E4: begin
        state_d = ST_E5;
      end
      ST_E5: begin
        mc         = $signed({32'b0, smag[49:16]});
        mean_acc_d = clamp_mean(s50[49] ? -mc : mc);
        state_d    = ST_VAR;
      end
      ST_VAR: begin
        if ((mode_q == MODE_CUM && count_q <= 32'd1) || vsum_q[VSUM_W-1] || vsum_q == '0) begin
          var_d   = VAR_W'(1);
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = $unsigned(vsum_q);
          div_den   = (mode_q == MODE_CUM) ? count_q - 1'b1 : DEN_W'(len_eff);
          state_d   = ST_VDIV;
        end
      end
      ST_VDIV: begin
        if (div_done) begin
          if (vq == '0) begin
            var_d = VAR_W'(1);
          end else if (vq > 48'(VAR_MAX)) begin
            var_d = VAR_W'(VAR_MAX);
          end else begin
            var_d = VAR_W'(vq);
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
      mean_acc_q  <= '0;
      count_q     <= '0;
      vsum_q      <= '0;
      wptr_q      <= '0;
      wtotal_q    <= '0;
      primed_q    <= 1'b0;
      prime_q     <= '0;
      wslots_q    <= '0;
    end else begin
      state_q    <= state_d;
      pass_q     <= pass_d;
      mean_acc_q <= mean_acc_d;
      count_q    <= count_d;
      vsum_q     <= vsum_d;
      wptr_q     <= wptr_d;
      wtotal_q   <= wtotal_d;
      primed_q   <= primed_d;
      prime_q    <= prime_d;
      wslots_q   <= wslots_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qneg_q   <= qneg_d;
    x_q      <= x_d;
    w_q      <= w_d;
    prev_q   <= prev_d;
    oldest_q <= oldest_d;
    op_a_q   <= op_a_d;
    op_b_q   <= op_b_d;
    op_neg_q <= op_neg_d;
    prod_q   <= op_a_q * op_b_q;
    t1_q     <= t1_d;
    var_q    <= var_d;
    if (out_load) begin
      mean_out_q <= mean_acc_q[ACC_W-1] ? MEAN_W'(-mq) : MEAN_W'(mq);
      var_out_q  <= var_q;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_out_q;
  assign variance_o  = var_out_q;
endmodule
`default_nettype wire

[verif/moving_average_variance_tracker_unit_tb.sv]
// Self-checking testbench of the moving average and variance tracker, all modes.
`timescale 1ns / 1ps
module moving_average_variance_tracker_unit_tb;
  import mavt_pkg::*;

  localparam int  WIN_MAX    = 64;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [WEIGHT_W-1:0]        weight;
  } request_t;

  typedef struct {
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic [WEIGHT_W-1:0] weight_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [MEAN_W-1:0] mean_o;
  logic [VAR_W-1:0] variance_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  moving_average_variance_tracker_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_i, .weight_i,
    .out_valid_o, .out_stall_i, .mean_o, .variance_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  request_t pending_q[$];
  stats_t   stats_q[$];
  int       error_count = 0;
  int       accepted_count = 0;
  longint   cycle_count = 0;

  // predictor state
  logic [1:0] cur_mode = MODE_CUM;
  logic [LEN_W-1:0] cur_len = 7'd1;
  longint mean_acc = 0;
  longint unsigned sample_count = 0;
  longint var_sum = 0;
  longint win_store [WIN_MAX];
  int unsigned win_ptr = 0;
  longint win_total = 0;
  bit primed = 0;
  longint prime_val = 0;
  int unsigned written = 0;

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > S64_MAX - b) return S64_MAX;
    if (b < 0 && a < S64_MIN - b) return S64_MIN;
    return a + b;
  endfunction

  function automatic longint dev_product(longint a, longint b);
    longint unsigned ua, ub, p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    if (ua > 64'hFFFF_FFFF) ua = 64'hFFFF_FFFF;
    if (ub > 64'hFFFF_FFFF) ub = 64'hFFFF_FFFF;
    p = (ua * ub) >> FRAC;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clamp_q16(longint m);
    if (m > (longint'(32767) <<< FRAC)) return longint'(32767) <<< FRAC;
    if (m < -(longint'(32768) <<< FRAC)) return -(longint'(32768) <<< FRAC);
    return m;
  endfunction

  function automatic longint spread(longint sum, longint unsigned div);
    longint q;
    if (sum <= 0 || div == 0) return 1;
    q = longint'(longint'(unsigned'(sum)) / div) >>> FRAC;
    q = longint'(longint'(unsigned'(sum)) / div);
    q = longint'(64'(unsigned'(sum)) / div) >>> FRAC;
    if (q < 1) return 1;
    if (q > VAR_MAX) return VAR_MAX;
    return q;
  endfunction

  function automatic stats_t update_stats(request_t r);
    longint x, xq, prev, m, oldest, oq, lim, vr;
    longint unsigned w;
    int unsigned len, p;
    stats_t s;
    x = r.sample;
    xq = x * ONE_Q16;
    w = r.weight;
    if (w > ONE_Q16) w = ONE_Q16;
    len = (cur_len < 1) ? 1 : (cur_len > WIN_MAX) ? WIN_MAX : cur_len;
    case (cur_mode)
      MODE_CUM: begin
        prev = mean_acc;
        if (sample_count < 64'hFFFF_FFFF) sample_count++;
        m = clamp_q16(prev + (xq - prev) / longint'(sample_count));
        mean_acc = m;
        var_sum = add_sat(var_sum, dev_product(xq - m, xq - prev));
      end
      MODE_WIN: begin
        if (!primed) begin
          primed = 1;
          prime_val = x;
          written = 0;
          win_ptr = 0;
          win_total = x * len;
          mean_acc = xq;
          var_sum = 0;
        end else begin
          p = win_ptr % WIN_MAX;
          oldest = (p < written) ? win_store[p] : prime_val;
          oq = oldest * ONE_Q16;
          prev = mean_acc;
          lim = longint'(32768) * WIN_MAX;
          win_total = win_total - oldest + x;
          if (win_total > lim) win_total = lim;
          if (win_total < -lim) win_total = -lim;
          m = clamp_q16((win_total * ONE_Q16) / longint'(len));
          mean_acc = m;
          var_sum = add_sat(var_sum, dev_product(xq - prev, xq - m));
          var_sum = add_sat(var_sum, -dev_product(oq - prev, oq - m));
          win_store[p] = x;
          if (written < p + 1) written = p + 1;
          win_ptr = (p + 1 >= len) ? 0 : p + 1;
        end
      end
      MODE_DECAY: begin
        m = (xq * longint'(w) + mean_acc * longint'(ONE_Q16 - w)) / ONE_Q16;
        mean_acc = clamp_q16(m);
      end
      default: ;
    endcase
    if (cur_mode == MODE_CUM)
      vr = (sample_count <= 1) ? 1 : spread(var_sum, sample_count - 1);
    else
      vr = spread(var_sum, len);
    s.mean = MEAN_W'(mean_acc / ONE_Q16);
    s.variance = VAR_W'(vr);
    return s;
  endfunction

  task automatic report(string what, longint got, longint exp_val);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, exp_val,
             accepted_count);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // driver
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    request_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        r.sample = sample_i;
        r.weight = weight_i;
        stats_q.push_back(update_stats(r));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          r = pending_q.pop_front();
          sample_i <= r.sample;
          weight_i <= r.weight;
          in_valid_i <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off
  int hold_left = 0;
  bit hold_done = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && accepted_count >= 60) begin
      hold_done = 1;
      hold_left = 3000;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      out_stall_i <= (stall_left > 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      accepted_count++;
      if (stats_q.size() == 0) begin
        report("unexpected result", mean_o, 0);
      end else begin
        e = stats_q.pop_front();
        if (mean_o !== e.mean) report("mean", mean_o, e.mean);
        if (variance_o !== e.variance) report("variance", variance_o, e.variance);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || stats_q.size() != 0 || in_valid_i || in_stall_o ||
           out_valid_o);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic configure(mode_e mode, logic [LEN_W-1:0] len);
    wait_idle();
    apb_write({REG_MODE, 2'b00}, APB_DW'(mode));
    apb_write({REG_LEN, 2'b00}, APB_DW'(len));
    cur_mode = mode;
    cur_len = len;
  endtask

  task automatic queue_request(int s, int w);
    request_t r;
    r.sample = SAMPLE_W'(s);
    r.weight = WEIGHT_W'(w);
    pending_q.push_back(r);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return 0;
      3: return $signed($urandom_range(0, 200)) - 100;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  function automatic int rand_weight();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return ONE_Q16;
      2: return $urandom_range(0, 131071);
      default: return $urandom_range(0, ONE_Q16);
    endcase
  endfunction

  task automatic random_burst(int n);
    repeat (n) queue_request(rand_sample(), rand_weight());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: cumulative with extremes, then each mode's corners
    configure(MODE_CUM, 7'd1);
    queue_request(32767, 0);
    queue_request(-32768, 131071);
    queue_request(32767, ONE_Q16);
    queue_request(-32768, 1);
    queue_request(0, 65535);
    queue_request(-1, 65537);
    queue_request(1, 0);
    queue_request(0, 0);
    configure(MODE_HOLD, 7'd0);
    queue_request(12345, ONE_Q16);
    queue_request(-32768, 0);
    configure(MODE_DECAY, 7'd5);
    queue_request(32767, ONE_Q16);
    queue_request(-32768, 131071);
    queue_request(-32768, 0);
    queue_request(100, 32768);
    configure(MODE_WIN, 7'd64);
    queue_request(32767, 0);
    queue_request(32767, 0);
    queue_request(-32768, 0);
    configure(MODE_WIN, 7'd1);
    queue_request(32767, 0);
    queue_request(32767, 0);
    queue_request(-32768, 0);

    // random phases across settings
    configure(MODE_CUM, 7'd3);
    random_burst(120);
    configure(MODE_WIN, 7'd64);
    random_burst(100);
    configure(MODE_WIN, 7'd0);
    random_burst(30);
    configure(MODE_WIN, 7'd127);
    random_burst(40);
    configure(MODE_WIN, 7'd5);
    random_burst(60);
    configure(MODE_DECAY, 7'd64);
    random_burst(80);
    configure(MODE_WIN, 7'($urandom_range(1, 64)));
    random_burst(60);
    configure(MODE_HOLD, 7'($urandom_range(0, 127)));
    random_burst(10);
    configure(MODE_WIN, 7'($urandom_range(0, 127)));
    random_burst(40);
    configure(MODE_CUM, 7'd64);
    random_burst(80);

    wait_idle();
    repeat (300) @(posedge clk_i);
    if (error_count == 0 && stats_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
